@@ hdl/aiffhp_pkg.sv @@
// ----------------------------------------------------------------------------
// aiffhp_pkg
// Shared types and constants for the AIFF 16-bit header parser.
// ----------------------------------------------------------------------------
package aiffhp_pkg;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_FORM  = 3'd1,
        ST_BAD_COMM  = 3'd2,
        ST_NOT_16BIT = 3'd3,
        ST_BAD_SSND  = 3'd4,
        ST_BAD_BLOCK = 3'd5
    } status_t;

    typedef struct packed {
        logic [32:0] data_offset;
        logic [31:0] sample_rate_fixed;
        logic [31:0] sample_frames;
        logic [15:0] channels;
        status_t     status;
    } result_t;

    typedef struct packed {
        logic       is_tag;
        logic [7:0] ch;
    } tag_t;

    localparam int unsigned POS_W = 6;

    // header byte positions
    localparam logic [POS_W-1:0] POS_COMM_START = 6'd12;
    localparam logic [POS_W-1:0] POS_COMM_SIZE  = 6'd19;
    localparam logic [POS_W-1:0] POS_CHANNELS   = 6'd21;
    localparam logic [POS_W-1:0] POS_FRAMES     = 6'd25;
    localparam logic [POS_W-1:0] POS_BITS       = 6'd27;
    localparam logic [POS_W-1:0] POS_EXPONENT   = 6'd29;
    localparam logic [POS_W-1:0] POS_MANT_FIRST = 6'd30;
    localparam logic [POS_W-1:0] POS_MANT_LAST  = 6'd37;
    localparam logic [POS_W-1:0] POS_SSND_START = 6'd38;
    localparam logic [POS_W-1:0] POS_OFFSET     = 6'd49;
    localparam logic [POS_W-1:0] POS_LAST       = 6'd53;

    localparam logic [31:0] COMM_SIZE      = 32'd18;
    localparam logic [15:0] BITS_REQUIRED  = 16'd16;
    localparam logic [32:0] HEADER_BYTES   = 33'd54;

    localparam logic [31:0] RATE_MIN_FIXED = 32'd4096;
    localparam logic [31:0] RATE_MAX_FIXED = 32'd4096000000;
    localparam logic [14:0] EXP_INF        = 15'h7FFF;
    // value = mant * 2^(exp - 16383 - 63) * 2^12
    localparam logic [14:0] EXP_UNITY      = 15'd16434;
    localparam logic [14:0] EXP_TOO_BIG    = 15'd16466;
    localparam logic [14:0] EXP_TOO_SMALL  = 15'd16370;

    function automatic tag_t tag_lookup(input logic [POS_W-1:0] pos);
        tag_t t;
        t.is_tag = 1'b1;
        t.ch     = 8'h00;
        case (pos)
            6'd0:    t.ch = "F";
            6'd1:    t.ch = "O";
            6'd2:    t.ch = "R";
            6'd3:    t.ch = "M";
            6'd8:    t.ch = "A";
            6'd9:    t.ch = "I";
            6'd10:   t.ch = "F";
            6'd11:   t.ch = "F";
            6'd12:   t.ch = "C";
            6'd13:   t.ch = "O";
            6'd14:   t.ch = "M";
            6'd15:   t.ch = "M";
            6'd38:   t.ch = "S";
            6'd39:   t.ch = "S";
            6'd40:   t.ch = "N";
            6'd41:   t.ch = "D";
            default: t.is_tag = 1'b0;
        endcase
        return t;
    endfunction

    function automatic status_t chunk_error(input logic [POS_W-1:0] pos);
        status_t s;
        if (pos < POS_COMM_START)
        begin
            s = ST_BAD_FORM;
        end
        else if (pos < POS_SSND_START)
        begin
            s = ST_BAD_COMM;
        end
        else
        begin
            s = ST_BAD_SSND;
        end
        return s;
    endfunction

endpackage

@@ hdl/aiffhp_rate_conv.sv @@
// ----------------------------------------------------------------------------
// aiffhp_rate_conv
// 80-bit extended sample rate to clamped unsigned 20.12 fixed point, registered.
// ----------------------------------------------------------------------------
module aiffhp_rate_conv
    import aiffhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [14:0] rate_exponent,
    input  logic [63:0] rate_mantissa,
    output logic [31:0] rate_fixed
);

    logic [31:0] rate_reg;
    logic [31:0] rate_next;
    logic [14:0] left_diff;
    logic [14:0] right_diff;
    logic [63:0] shifted;

    assign left_diff  = rate_exponent - EXP_UNITY;
    assign right_diff = EXP_UNITY - rate_exponent;

    always_comb
    begin
        shifted   = '0;
        rate_next = RATE_MIN_FIXED;
        if (rate_exponent == EXP_INF)
        begin
            rate_next = RATE_MAX_FIXED;
        end
        else if (rate_mantissa == '0)
        begin
            rate_next = RATE_MIN_FIXED;
        end
        else if (rate_exponent >= EXP_TOO_BIG)
        begin
            rate_next = RATE_MAX_FIXED;
        end
        else if (rate_exponent > EXP_TOO_SMALL)
        begin
            if (rate_exponent >= EXP_UNITY)
            begin
                // shift up by 0..31; a mantissa above 32 bits always saturates
                shifted = {32'd0, rate_mantissa[31:0]} << left_diff[4:0];
                if (rate_mantissa[63:32] != '0)
                begin
                    shifted = 64'hFFFF_FFFF_FFFF_FFFF;
                end
            end
            else
            begin
                shifted = rate_mantissa >> right_diff[5:0];
            end
            if (shifted > {32'd0, RATE_MAX_FIXED})
            begin
                rate_next = RATE_MAX_FIXED;
            end
            else if (shifted < {32'd0, RATE_MIN_FIXED})
            begin
                rate_next = RATE_MIN_FIXED;
            end
            else
            begin
                rate_next = shifted[31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= RATE_MIN_FIXED;
        end
        else
        begin
            rate_reg <= rate_next;
        end
    end

    assign rate_fixed = rate_reg;

endmodule

@@ hdl/aiffhp_parser.sv @@
// ----------------------------------------------------------------------------
// aiffhp_parser
// Per-byte header state update; flags a result at the end of a header or error.
// ----------------------------------------------------------------------------
module aiffhp_parser
    import aiffhp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       beat_en,
    input  logic [7:0] data_byte,
    input  logic       first_byte,
    input  logic       stream_end,
    output logic       emit,
    output result_t    result
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             finished_reg, finished_next;
    logic [31:0]      acc_reg, acc_next;
    logic [15:0]      chan_reg, chan_next;
    logic [31:0]      frames_reg, frames_next;
    logic [14:0]      exp_reg, exp_next;
    logic [63:0]      mant_reg, mant_next;
    logic [31:0]      skip_reg, skip_next;
    logic             bits_bad_reg, bits_bad_next;

    logic [POS_W-1:0] pos_cur;
    logic [31:0]      acc_new;
    logic [63:0]      mant_base;
    tag_t             tag;
    logic [31:0]      rate_fixed;

    aiffhp_rate_conv u_rate (
        .clk           (clk),
        .rst_n         (rst_n),
        .rate_exponent (exp_reg),
        .rate_mantissa (mant_reg),
        .rate_fixed    (rate_fixed)
    );

    assign pos_cur   = first_byte ? '0 : pos_reg;
    assign acc_new   = first_byte ? {24'd0, data_byte} : {acc_reg[23:0], data_byte};
    assign mant_base = first_byte ? '0 : mant_reg;
    assign tag       = tag_lookup(pos_cur);

    always_comb
    begin
        pos_next      = pos_reg;
        finished_next = finished_reg;
        acc_next      = acc_reg;
        chan_next     = chan_reg;
        frames_next   = frames_reg;
        exp_next      = exp_reg;
        mant_next     = mant_reg;
        skip_next     = skip_reg;
        bits_bad_next = bits_bad_reg;
        emit          = 1'b0;
        result        = '0;

        if (beat_en)
        begin
            if (stream_end)
            begin
                // truncated file: report the chunk holding the missing byte
                if (!finished_reg)
                begin
                    emit          = 1'b1;
                    result.status = chunk_error(pos_reg);
                    finished_next = 1'b1;
                end
            end
            else if (first_byte || !finished_reg)
            begin
                finished_next = 1'b0;
                acc_next      = acc_new;
                mant_next     = mant_base;
                if (first_byte)
                begin
                    chan_next     = '0;
                    frames_next   = '0;
                    exp_next      = '0;
                    skip_next     = '0;
                    bits_bad_next = 1'b0;
                end

                if (pos_cur == POS_CHANNELS)
                begin
                    chan_next = acc_new[15:0];
                end
                if (pos_cur == POS_FRAMES)
                begin
                    frames_next = acc_new;
                end
                if (pos_cur == POS_BITS)
                begin
                    bits_bad_next = (acc_new[15:0] != BITS_REQUIRED);
                end
                if (pos_cur == POS_EXPONENT)
                begin
                    exp_next = acc_new[14:0];
                end
                if (pos_cur >= POS_MANT_FIRST && pos_cur <= POS_MANT_LAST)
                begin
                    mant_next = {mant_base[55:0], data_byte};
                end
                if (pos_cur == POS_OFFSET)
                begin
                    skip_next = acc_new;
                end

                if (tag.is_tag && data_byte != tag.ch)
                begin
                    emit          = 1'b1;
                    result.status = chunk_error(pos_cur);
                    finished_next = 1'b1;
                end
                else if (pos_cur == POS_COMM_SIZE && acc_new != COMM_SIZE)
                begin
                    emit          = 1'b1;
                    result.status = ST_BAD_COMM;
                    finished_next = 1'b1;
                end
                else if (pos_cur == POS_MANT_LAST && bits_bad_reg)
                begin
                    emit          = 1'b1;
                    result.status = ST_NOT_16BIT;
                    finished_next = 1'b1;
                end
                else if (pos_cur == POS_LAST)
                begin
                    emit          = 1'b1;
                    finished_next = 1'b1;
                    if (acc_new != '0)
                    begin
                        result.status = ST_BAD_BLOCK;
                    end
                    else
                    begin
                        result.status            = ST_OK;
                        result.channels          = chan_reg;
                        result.sample_frames     = frames_reg;
                        result.sample_rate_fixed = rate_fixed;
                        result.data_offset       = {1'b0, skip_reg} + HEADER_BYTES;
                    end
                end
                else
                begin
                    pos_next = pos_cur + 6'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            finished_reg <= 1'b1;
            bits_bad_reg <= 1'b0;
            exp_reg      <= '0;
            mant_reg     <= '0;
        end
        else
        begin
            pos_reg      <= pos_next;
            finished_reg <= finished_next;
            bits_bad_reg <= bits_bad_next;
            exp_reg      <= exp_next;
            mant_reg     <= mant_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        chan_reg   <= chan_next;
        frames_reg <= frames_next;
        skip_reg   <= skip_next;
    end

    a_emit_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> finished_reg)
        else $error("parser still active after a result");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST)
        else $error("byte position past end of header");

    a_error_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && result.status != ST_OK) |->
        (result.channels == '0 && result.sample_frames == '0 &&
         result.sample_rate_fixed == '0 && result.data_offset == '0))
        else $error("error result carries payload");

    a_truncation_only_active: assert property (@(posedge clk) disable iff (!rst_n)
        (beat_en && stream_end && finished_reg) |-> !emit)
        else $error("result for end of stream while idle");

endmodule

@@ hdl/aiff16_header_parser_top.sv @@
// Latency: a result beat is valid the cycle after the final header byte, the
//   first failing byte, or a stream_end beat during an unfinished header is accepted.
// Throughput: one input beat per cycle; the single output register refills in
//   the same cycle it is taken, so s_tready only drops while a result stalls.
// The rate converter is registered off the stored mantissa and settles well before byte 53.
// Reset: parser idles until a beat with first_byte set; no output pending.
// ----------------------------------------------------------------------------
// aiff16_header_parser_top
// AIFF 16-bit header parser: byte stream in, one header summary beat out.
// ----------------------------------------------------------------------------
module aiff16_header_parser_top
    import aiffhp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic [1:0]   s_tuser,   // [0] first_byte, [1] stream_end
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata    // [2:0] status, [18:3] channels,
                                    // [50:19] sample_frames,
                                    // [82:51] sample_rate_fixed,
                                    // [115:83] data_offset, [119:116] zero
);

    logic    beat_en;
    logic    emit;
    result_t result;

    logic         m_tvalid_reg, m_tvalid_next;
    logic [115:0] m_tdata_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign beat_en  = s_tvalid && s_tready;

    aiffhp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_en    (beat_en),
        .data_byte  (s_tdata),
        .first_byte (s_tuser[0]),
        .stream_end (s_tuser[1]),
        .emit       (emit),
        .result     (result)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (emit)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            m_tdata_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, m_tdata_reg};

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tready) |-> !emit)
        else $error("pending result overwritten");

    a_ok_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_tdata_reg[2:0] == ST_OK) |->
        (m_tdata_reg[115:83] >= HEADER_BYTES))
        else $error("data offset below header length");

    a_ok_rate: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_tdata_reg[2:0] == ST_OK) |->
        (m_tdata_reg[82:51] >= RATE_MIN_FIXED && m_tdata_reg[82:51] <= RATE_MAX_FIXED))
        else $error("sample rate outside clamp range");

endmodule
